### rtl/lcg_pkg.sv
`timescale 1ns / 1ps
// lcg_pkg: shared types and constants of the lcg random unit
// no dependencies; used by the controller, the datapath and the top level

package lcg_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W = 5;

	localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
	localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;
	localparam logic [WORD_W-1:0] POS_MASK = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SEED_ONE = 32'd1;
	localparam logic [7:0] PCT_FULL = 8'd100;
	localparam logic [6:0] PCT_MUL = 7'd100;
	localparam logic [CNT_W-1:0] MOD_LAST = 5'd30;

	typedef enum logic [2:0] {
		ACT_SEED     = 3'd0,
		ACT_RAW      = 3'd1,
		ACT_POS      = 3'd2,
		ACT_RANGE_EX = 3'd3,
		ACT_RANGE_IN = 3'd4,
		ACT_BOOL     = 3'd5,
		ACT_PROB     = 3'd6,
		ACT_MASK     = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_USE,
		ST_MOD,
		ST_MASK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic seed;
		logic step;
		logic mod_init;
		logic mod_step;
		logic mask_shift;
		logic emit;
	} cmd_t;

	typedef struct packed {
		act_t action;
		logic range_deg;
		logic prob_zero;
		logic prob_full;
		logic pct_zero;
		logic pct_full;
	} status_t;

endpackage

### rtl/lcg_if.sv
`timescale 1ns / 1ps
// lcg_in_if and lcg_out_if: valid/ready channels of the lcg random unit
// no dependencies

interface lcg_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [31:0]        seed_value;
	logic signed [31:0] low_bound;
	logic signed [31:0] high_bound;
	logic [32:0]        probability_q32;
	logic [7:0]         percent;

	modport source (
		output valid, action, seed_value, low_bound, high_bound, probability_q32, percent,
		input  ready
	);
	modport sink (
		input  valid, action, seed_value, low_bound, high_bound, probability_q32, percent,
		output ready
	);
endinterface

interface lcg_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

### rtl/lcg_ctrl.sv
`timescale 1ns / 1ps
// lcg_ctrl: sequencer of the lcg random unit, issues datapath commands
// depends on lcg_pkg

module lcg_ctrl #(
	parameter int unsigned MASK_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lcg_pkg::status_t status,
	output lcg_pkg::cmd_t    cmd
);
	import lcg_pkg::*;

	localparam logic [CNT_W-1:0] MASK_LAST = CNT_W'(MASK_BITS - 1);

	state_t          state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cnt_d = '0;
				case (status.action)
					ACT_SEED: begin
						cmd.seed = 1'b1;
						state_d  = ST_FIN;
					end
					ACT_RANGE_EX, ACT_RANGE_IN: begin
						if (status.range_deg) begin
							state_d = ST_FIN;
						end else begin
							cmd.step = 1'b1;
							state_d  = ST_USE;
						end
					end
					ACT_PROB: begin
						cmd.step = !(status.prob_zero || status.prob_full);
						state_d  = ST_FIN;
					end
					ACT_MASK: begin
						if (status.pct_zero || status.pct_full) begin
							state_d = ST_FIN;
						end else begin
							cmd.step = 1'b1;
							state_d  = ST_MASK;
						end
					end
					default: begin
						cmd.step = 1'b1;
						state_d  = ST_FIN;
					end
				endcase
			end
			ST_USE: begin
				cmd.mod_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == MOD_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_MASK: begin
				cmd.mask_shift = 1'b1;
				if (cnt_q == MASK_LAST) begin
					state_d = ST_FIN;
				end else begin
					cmd.step = 1'b1;
					cnt_d    = cnt_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/lcg_dp.sv
`timescale 1ns / 1ps
// lcg_dp: generator state, bit-serial modulo, mask shifter and result register
// depends on lcg_pkg

module lcg_dp #(
	parameter int unsigned MASK_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lcg_pkg::cmd_t      cmd,
	output lcg_pkg::status_t   status,
	input  logic [2:0]         action,
	input  logic [31:0]        seed_value,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	input  logic [32:0]        probability_q32,
	input  logic [7:0]         percent,
	output logic [31:0]        value
);
	import lcg_pkg::*;

	act_t               action_q;
	logic [31:0]        seed_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic [32:0]        prob_q;
	logic [7:0]         pct_q;

	logic [31:0]          lcg_q;
	logic [31:0]          lcg_next;
	logic [32:0]          span_q;
	logic [32:0]          span_d;
	logic [31:0]          rem_q;
	logic [30:0]          dvd_q;
	logic [32:0]          trial;
	logic [MASK_BITS-1:0] acc_q;
	logic [MASK_BITS-1:0] acc_next;
	logic [38:0]          scaled;
	logic                 hit;
	logic [31:0]          result;
	logic [31:0]          value_q;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= act_t'(action);
			seed_q   <= seed_value;
			lo_q     <= low_bound;
			hi_q     <= high_bound;
			prob_q   <= probability_q32;
			pct_q    <= percent;
		end
	end

	// generator state
	assign lcg_next = lcg_q * LCG_MUL + LCG_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= SEED_ONE;
		end else if (cmd.seed) begin
			lcg_q <= (seed_q == '0) ? SEED_ONE : seed_q;
		end else if (cmd.step) begin
			lcg_q <= lcg_next;
		end
	end

	// status
	always_comb begin
		status.action    = action_q;
		status.range_deg = (hi_q <= lo_q);
		status.prob_zero = (prob_q == '0);
		status.prob_full = prob_q[32];
		status.pct_zero  = (pct_q == '0);
		status.pct_full  = (pct_q >= PCT_FULL);
	end

	// range: restoring modulo, one dividend bit per cycle
	assign span_d = 33'({hi_q[31], hi_q} - {lo_q[31], lo_q})
		+ 33'(action_q == ACT_RANGE_IN);
	assign trial = {rem_q, dvd_q[30]};

	always_ff @(posedge clk) begin
		if (cmd.mod_init) begin
			span_q <= span_d;
			rem_q  <= '0;
			dvd_q  <= lcg_q[30:0];
		end else if (cmd.mod_step) begin
			rem_q  <= (trial >= span_q) ? 32'(trial - span_q) : trial[31:0];
			dvd_q  <= {dvd_q[29:0], 1'b0};
		end
	end

	// bit mask: draw i lands in bit i after all shifts
	assign scaled = 39'(lcg_q) * 39'(PCT_MUL);
	assign hit    = ({1'b0, scaled[38:32]} < pct_q);

	always_comb begin
		acc_next                = acc_q >> 1;
		acc_next[MASK_BITS-1]   = hit;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (cmd.mask_shift) begin
			acc_q <= acc_next;
		end
	end

	// result select
	always_comb begin
		case (action_q)
			ACT_SEED: begin
				result = '0;
			end
			ACT_RAW: begin
				result = lcg_q;
			end
			ACT_POS: begin
				result = lcg_q & POS_MASK;
			end
			ACT_RANGE_EX, ACT_RANGE_IN: begin
				result = status.range_deg ? lo_q : 32'(lo_q + rem_q);
			end
			ACT_BOOL: begin
				result = {31'b0, lcg_q[0]};
			end
			ACT_PROB: begin
				if (status.prob_zero) begin
					result = '0;
				end else if (status.prob_full) begin
					result = 32'd1;
				end else begin
					result = {31'b0, (lcg_q < prob_q[31:0])};
				end
			end
			ACT_MASK: begin
				if (status.pct_zero) begin
					result = '0;
				end else if (status.pct_full) begin
					result = 32'({MASK_BITS{1'b1}});
				end else begin
					result = 32'(acc_q);
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= result;
		end
	end

	assign value = value_q;

endmodule

### rtl/lcg_random_unit.sv
`timescale 1ns / 1ps
// lcg_random_unit: top level of the 32-bit lcg random number unit
// depends on lcg_pkg, lcg_if, lcg_ctrl and lcg_dp

// The unit keeps a 32-bit generator state (reset value 1) advanced as
// state*1664525+1013904223. It handles one item at a time and then accepts
// the next while its result still waits in the output register. Seed, raw,
// positive, bool and probability items pass through the decide and finish
// states; a range item also passes the use and modulo states, where the
// bit-serial modulo retires one of the 31 dividend bits per cycle; a bit mask
// item passes the mask state, one generator step per mask bit. Degenerate
// bounds, probability 0 or certain, and percent 0 or 100 and above go straight
// from decide to finish and leave the state unchanged.

module lcg_random_unit #(
	parameter int unsigned MASK_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	lcg_in_if.sink    in_item,
	lcg_out_if.source out_item
);
	import lcg_pkg::*;

	cmd_t    cmd;
	status_t status;

	lcg_ctrl #(
		.MASK_BITS(MASK_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_item.valid),
		.in_ready  (in_item.ready),
		.out_valid (out_item.valid),
		.out_ready (out_item.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lcg_dp #(
		.MASK_BITS(MASK_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.action          (in_item.action),
		.seed_value      (in_item.seed_value),
		.low_bound       (in_item.low_bound),
		.high_bound      (in_item.high_bound),
		.probability_q32 (in_item.probability_q32),
		.percent         (in_item.percent),
		.value           (out_item.value)
	);

endmodule

### bench/tb_lcg_random_unit.sv
`timescale 1ns / 1ps
// tb_lcg_random_unit: self-checking bench for the lcg random unit, directed then random items
// depends on lcg_pkg, lcg_in_if / lcg_out_if and lcg_random_unit; keeps its own generator copy

module tb_lcg_random_unit;
	import lcg_pkg::*;

	localparam int MASK_N = 32;
	localparam int RANDOM_ITEMS = 1480;
	localparam int HOLD_AT = 2000;
	localparam int HOLD_LEN = 400;
	localparam int CALM_FROM = 6000;
	localparam int CALM_TO = 12000;

	typedef struct {
		act_t               action;
		logic [31:0]        seed_value;
		logic signed [31:0] low_bound;
		logic signed [31:0] high_bound;
		logic [32:0]        probability_q32;
		logic [7:0]         percent;
	} lcg_req_t;

	logic clk;
	logic arst_n;

	lcg_in_if in_item();
	lcg_out_if out_item();

	lcg_random_unit #(.MASK_BITS(MASK_N)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.out_item(out_item)
	);

	lcg_req_t    item_q[$];
	logic [31:0] value_q[$];
	lcg_req_t    cur_req;
	logic [31:0] gen_state;
	logic [31:0] want_value;
	int          errors;
	int          n_results;
	int          per_action[8];
	int          run_cycles;
	int          hold_left;
	logic        calm;

	assign calm = (run_cycles >= CALM_FROM) && (run_cycles < CALM_TO);

	// generator copy
	function automatic logic [31:0] advance_gen();
		gen_state = gen_state * LCG_MUL + LCG_ADD;
		return gen_state;
	endfunction

	function automatic logic [31:0] pick_in_range(logic signed [31:0] lo, logic signed [31:0] hi,
			bit incl);
		logic [32:0] span;
		logic [63:0] pick;
		if (hi <= lo)
			return lo;
		span = {1'b0, 32'(hi - lo)} + 33'(incl);
		pick = 64'(advance_gen() & POS_MASK) % 64'(span);
		return lo + pick[31:0];
	endfunction

	function automatic logic [31:0] draw_mask(logic [7:0] pct);
		logic [31:0] bits;
		logic [63:0] limit;
		int i;
		bits = '0;
		if (pct == 8'd0)
			return '0;
		if (pct >= PCT_FULL)
			return 32'((64'd1 << MASK_N) - 64'd1);
		limit = {24'd0, pct, 32'd0};
		for (i = 0; i < MASK_N; i++) begin
			if (64'(advance_gen()) * 64'd100 < limit)
				bits[i] = 1'b1;
		end
		return bits;
	endfunction

	function automatic logic [31:0] predict_value(lcg_req_t r);
		case (r.action)
			ACT_SEED: begin
				gen_state = (r.seed_value == 32'd0) ? SEED_ONE : r.seed_value;
				return '0;
			end
			ACT_RAW: return advance_gen();
			ACT_POS: return advance_gen() & POS_MASK;
			ACT_RANGE_EX: return pick_in_range(r.low_bound, r.high_bound, 1'b0);
			ACT_RANGE_IN: return pick_in_range(r.low_bound, r.high_bound, 1'b1);
			ACT_BOOL: return advance_gen() & 32'd1;
			ACT_PROB: begin
				if (r.probability_q32 == 33'd0)
					return 32'd0;
				if (r.probability_q32[32])
					return 32'd1;
				return (advance_gen() < r.probability_q32[31:0]) ? 32'd1 : 32'd0;
			end
			default: return draw_mask(r.percent);
		endcase
	endfunction

	task automatic add_req(act_t a, logic [31:0] seed, logic signed [31:0] lo,
			logic signed [31:0] hi, logic [32:0] prob, logic [7:0] pct);
		lcg_req_t r;
		r.action = a;
		r.seed_value = seed;
		r.low_bound = lo;
		r.high_bound = hi;
		r.probability_q32 = prob;
		r.percent = pct;
		item_q.push_back(r);
	endtask

	function automatic logic signed [31:0] pick_bound();
		case ($urandom_range(0, 4))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic lcg_req_t random_req();
		lcg_req_t r;
		r.action = ($urandom_range(0, 99) < 5) ? ACT_SEED : act_t'(3'($urandom_range(1, 7)));
		r.seed_value = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom());
		case ($urandom_range(0, 3))
			0: begin
				r.low_bound = $urandom();
				r.high_bound = $urandom();
			end
			1: begin
				r.low_bound = $urandom();
				r.high_bound = r.low_bound + 32'($urandom_range(0, 24)) - 32'sd4;
			end
			2: begin
				r.low_bound = pick_bound();
				r.high_bound = pick_bound();
			end
			default: begin
				r.low_bound = 32'($urandom_range(0, 2000)) - 32'sd1000;
				r.high_bound = r.low_bound + 32'($urandom_range(0, 60)) - 32'sd10;
			end
		endcase
		case ($urandom_range(0, 5))
			0: r.probability_q32 = 33'd0;
			1: r.probability_q32 = 33'h1_0000_0000;
			2: r.probability_q32 = {1'b1, 32'($urandom())};
			3: r.probability_q32 = 33'($urandom_range(1, 16));
			default: r.probability_q32 = {1'b0, 32'($urandom())};
		endcase
		r.percent = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(1, 99));
		return r;
	endfunction

	task automatic note_fail(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sender side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_item.valid <= 1'b0;
		end else begin
			if (in_item.valid && in_item.ready) begin
				value_q.push_back(predict_value(cur_req));
				per_action[int'(cur_req.action)]++;
			end
			if (!in_item.valid || in_item.ready) begin
				if (item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
					cur_req = item_q.pop_front();
					in_item.action <= cur_req.action;
					in_item.seed_value <= cur_req.seed_value;
					in_item.low_bound <= cur_req.low_bound;
					in_item.high_bound <= cur_req.high_bound;
					in_item.probability_q32 <= cur_req.probability_q32;
					in_item.percent <= cur_req.percent;
					in_item.valid <= 1'b1;
				end else begin
					in_item.valid <= 1'b0;
				end
			end
		end
	end

	// cycle count and long output hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cycles <= 0;
			hold_left <= 0;
		end else begin
			run_cycles <= run_cycles + 1;
			if (run_cycles == HOLD_AT)
				hold_left <= HOLD_LEN;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
		end
	end

	// receiver side and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_item.ready <= 1'b0;
		end else begin
			if (out_item.valid && out_item.ready) begin
				n_results++;
				if (value_q.size() == 0) begin
					note_fail($sformatf("unexpected value %h", out_item.value));
				end else begin
					want_value = value_q.pop_front();
					if (out_item.value !== want_value)
						note_fail($sformatf("value expected %h got %h", want_value,
							out_item.value));
				end
			end
			out_item.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 11);
		end
	end

	initial begin
		arst_n <= 1'b0;
		gen_state = SEED_ONE;
		errors = 0;
		n_results = 0;
		foreach (per_action[i])
			per_action[i] = 0;

		add_req(ACT_RAW, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_SEED, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_RAW, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_SEED, 32'hFFFF_FFFF, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_POS, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_RANGE_EX, 32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 33'd0, 8'd0);
		add_req(ACT_RANGE_IN, 32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 33'd0, 8'd0);
		add_req(ACT_RANGE_EX, 32'd0, 32'sd5, 32'sd5, 33'd0, 8'd0);
		add_req(ACT_RANGE_IN, 32'd0, 32'sd10, -32'sd10, 33'd0, 8'd0);
		add_req(ACT_RANGE_EX, 32'd0, -32'sd7, -32'sd6, 33'd0, 8'd0);
		add_req(ACT_RANGE_IN, 32'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 33'd0, 8'd0);
		add_req(ACT_RANGE_IN, 32'd0, -32'sd3, 32'sd3, 33'd0, 8'd0);
		add_req(ACT_BOOL, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_PROB, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_PROB, 32'd0, 32'sd0, 32'sd0, 33'h1_0000_0000, 8'd0);
		add_req(ACT_PROB, 32'd0, 32'sd0, 32'sd0, 33'h1_FFFF_FFFF, 8'd0);
		add_req(ACT_PROB, 32'd0, 32'sd0, 32'sd0, 33'd1, 8'd0);
		add_req(ACT_PROB, 32'd0, 32'sd0, 32'sd0, 33'h0_FFFF_FFFF, 8'd0);
		add_req(ACT_MASK, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd0);
		add_req(ACT_MASK, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd100);
		add_req(ACT_MASK, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd255);
		add_req(ACT_MASK, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd1);
		add_req(ACT_MASK, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd99);
		add_req(ACT_MASK, 32'd0, 32'sd0, 32'sd0, 33'd0, 8'd50);
		add_req(ACT_SEED, 32'd12345, 32'sd0, 32'sd0, 33'd0, 8'd0);
		repeat (RANDOM_ITEMS)
			item_q.push_back(random_req());

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (item_q.size() != 0 || in_item.valid)
			@(posedge clk);
		while (value_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("items seed/raw/pos/range-ex/range-in/bool/prob/mask: %0d %0d %0d %0d %0d %0d %0d %0d",
			per_action[0], per_action[1], per_action[2], per_action[3],
			per_action[4], per_action[5], per_action[6], per_action[7]);
		$display("%0d values checked, %0d mismatches, one %0d-cycle output hold-off included",
			n_results, errors, HOLD_LEN);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/lcg_pkg.sv
rtl/lcg_if.sv
rtl/lcg_ctrl.sv
rtl/lcg_dp.sv
rtl/lcg_random_unit.sv
bench/tb_lcg_random_unit.sv
